[design/olt_pkg.sv]
package olt_pkg;

	localparam int ORDER_SLOTS_DEF = 1024;
	localparam int IDX_W = 10;
	localparam int QTY_W = 32;
	localparam int PRICE_W = 40;
	localparam int TIME_W = 64;

	// Order lifecycle states.
	localparam logic [2:0] ST_SENT     = 3'd0;
	localparam logic [2:0] ST_ACKED    = 3'd1;
	localparam logic [2:0] ST_PARTIAL  = 3'd2;
	localparam logic [2:0] ST_FILLED   = 3'd3;
	localparam logic [2:0] ST_REJECTED = 3'd4;
	localparam logic [2:0] ST_EXPIRED  = 3'd5;
	localparam logic [2:0] ST_CANCELED = 3'd6;

	// Report kinds.
	localparam logic [2:0] RPT_ACK    = 3'd0;
	localparam logic [2:0] RPT_FILL   = 3'd1;
	localparam logic [2:0] RPT_REJECT = 3'd2;
	localparam logic [2:0] RPT_EXPIRE = 3'd3;
	localparam logic [2:0] RPT_CANCEL = 3'd4;

	localparam logic ACT_SUBMIT = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	localparam logic [7:0] ERR_NONE        = 8'd0;
	localparam logic [7:0] ERR_IOC_EXPIRED = 8'd1;

	// Record held per order slot; live marks a slot that holds an order.
	typedef struct packed {
		logic              live;
		logic [2:0]        life;
		logic [QTY_W-1:0]  target;
		logic [QTY_W-1:0]  filled;
		logic [15:0]       instrument;
		logic [1:0]        venue;
		logic              side;
		logic [31:0]       parent;
		logic [TIME_W-1:0] sent_time;
		logic [TIME_W-1:0] ack_time;
		logic [TIME_W-1:0] done_time;
		logic [7:0]        error;
	} order_rec_t;

	// One classified word handed from the front to the back.
	typedef struct packed {
		logic               in_range;
		logic               action;
		logic [IDX_W-1:0]   index;
		logic [2:0]         kind;
		logic [QTY_W-1:0]   quantity;
		logic [PRICE_W-1:0] price;
		logic [TIME_W-1:0]  time_ns;
		logic [15:0]        instrument;
		logic [1:0]         venue;
		logic               side;
		logic [31:0]        parent_id;
		logic [7:0]         reason;
	} olt_cmd_t;

endpackage

[design/olt_ram.sv]
module olt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/olt_front.sv]
module olt_front import olt_pkg::*; #(
	parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  logic               action,
	input  logic [IDX_W-1:0]   order_index,
	input  logic [2:0]         report_kind,
	input  logic [QTY_W-1:0]   quantity,
	input  logic [PRICE_W-1:0] price,
	input  logic [TIME_W-1:0]  time_ns,
	input  logic [15:0]        instrument,
	input  logic [1:0]         venue,
	input  logic               side,
	input  logic [31:0]        parent_id,
	input  logic [7:0]         reason_code,
	output logic               cmd_valid,
	output olt_cmd_t           cmd,
	input  logic               cmd_take
);

	// Two-entry queue between front and back.
	olt_cmd_t   buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	olt_cmd_t   new_cmd;
	logic       push, pop;

	// Classify: range check of the slot number.
	always_comb begin
		new_cmd.in_range   = ({22'd0, order_index} < 32'(ORDER_SLOTS));
		new_cmd.action     = action;
		new_cmd.index      = order_index;
		new_cmd.kind       = report_kind;
		new_cmd.quantity   = quantity;
		new_cmd.price      = price;
		new_cmd.time_ns    = time_ns;
		new_cmd.instrument = instrument;
		new_cmd.venue      = venue;
		new_cmd.side       = side;
		new_cmd.parent_id  = parent_id;
		new_cmd.reason     = reason_code;
	end

	assign stall     = (cnt_q == 2'd2);
	assign push      = valid && !stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = buf_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= new_cmd;
		end
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[design/olt_back.sv]
module olt_back import olt_pkg::*; #(
	parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  olt_cmd_t           cmd,
	output logic               cmd_take,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               known,
	output logic [2:0]         order_status,
	output logic [QTY_W-1:0]   filled_total,
	output logic [7:0]         error_code,
	output logic               fill_valid,
	output logic [15:0]        fill_instrument,
	output logic [1:0]         fill_venue,
	output logic               fill_side,
	output logic [PRICE_W-1:0] fill_price,
	output logic [QTY_W-1:0]   fill_quantity,
	output logic [TIME_W-1:0]  fill_time,
	output logic [31:0]        fill_parent
);

	localparam int AW = $clog2(ORDER_SLOTS);
	localparam int RW = $bits(order_rec_t);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC} state_t;

	state_t     state_q;
	olt_cmd_t   cmd_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr, ram_waddr;
	order_rec_t rd_rec, nxt;
	logic [RW-1:0] ram_wdata;
	logic       slot_ok, wr_en, fill, clearing, ram_we, emit;
	logic [QTY_W:0] sum;
	logic [QTY_W-1:0] sat;
	logic       out_free;

	assign addr     = cmd_q.index[AW-1:0];
	assign out_free = !out_valid || !out_stall;
	assign cmd_take = (state_q == S_IDLE);
	assign slot_ok  = cmd_q.in_range && rd_rec.live;
	assign emit     = (state_q == S_EXEC) && out_free;

	// The clearing pass after reset writes every slot empty.
	assign clearing  = (state_q == S_CLEAR);
	assign ram_we    = wr_en || clearing;
	assign ram_waddr = clearing ? clr_q : addr;
	assign ram_wdata = clearing ? {RW{1'b0}} : nxt;

	olt_ram #(.WIDTH(RW), .DEPTH(ORDER_SLOTS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (state_q == S_READ),
		.raddr(addr),
		.rdata(rd_rec)
	);

	// Next record for the addressed slot.
	always_comb begin
		nxt   = rd_rec;
		wr_en = 1'b0;
		fill  = 1'b0;
		sum   = {1'b0, rd_rec.filled} + {1'b0, cmd_q.quantity};
		sat   = sum[QTY_W] ? '1 : sum[QTY_W-1:0];
		if (state_q == S_EXEC && out_free && cmd_q.in_range) begin
			if (cmd_q.action == ACT_SUBMIT) begin
				if (!rd_rec.live) begin
					wr_en          = 1'b1;
					nxt.live       = 1'b1;
					nxt.life       = ST_SENT;
					nxt.target     = cmd_q.quantity;
					nxt.filled     = '0;
					nxt.instrument = cmd_q.instrument;
					nxt.venue      = cmd_q.venue;
					nxt.side       = cmd_q.side;
					nxt.parent     = cmd_q.parent_id;
					nxt.sent_time  = cmd_q.time_ns;
					nxt.ack_time   = '0;
					nxt.done_time  = '0;
					nxt.error      = ERR_NONE;
				end
			end else if (rd_rec.live) begin
				wr_en = 1'b1;
				case (cmd_q.kind)
					RPT_ACK: begin
						if (rd_rec.life == ST_SENT) begin
							nxt.life     = ST_ACKED;
							nxt.ack_time = cmd_q.time_ns;
						end
					end
					RPT_FILL: begin
						fill       = 1'b1;
						nxt.filled = sat;
						if (sat >= rd_rec.target) begin
							nxt.life      = ST_FILLED;
							nxt.done_time = cmd_q.time_ns;
						end else begin
							nxt.life = ST_PARTIAL;
						end
					end
					RPT_REJECT: begin
						nxt.life      = (rd_rec.filled != '0) ? ST_PARTIAL : ST_REJECTED;
						nxt.error     = cmd_q.reason;
						nxt.done_time = cmd_q.time_ns;
					end
					RPT_EXPIRE: begin
						nxt.life      = (rd_rec.filled != '0) ? ST_PARTIAL : ST_EXPIRED;
						nxt.error     = (cmd_q.reason == ERR_NONE) ? ERR_IOC_EXPIRED
							: cmd_q.reason;
						nxt.done_time = cmd_q.time_ns;
					end
					RPT_CANCEL: begin
						nxt.life      = ST_CANCELED;
						nxt.done_time = cmd_q.time_ns;
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
		end
	end

	// Sequencer, clearing counter and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_q           <= '0;
			out_valid       <= 1'b0;
			known           <= 1'b0;
			order_status    <= 3'd0;
			filled_total    <= '0;
			error_code      <= 8'd0;
			fill_valid      <= 1'b0;
			fill_instrument <= 16'd0;
			fill_venue      <= 2'd0;
			fill_side       <= 1'b0;
			fill_price      <= '0;
			fill_quantity   <= '0;
			fill_time       <= '0;
			fill_parent     <= 32'd0;
		end else begin
			out_valid <= emit || (out_valid && out_stall);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(ORDER_SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (emit) begin
				known           <= slot_ok || wr_en;
				order_status    <= (slot_ok || wr_en) ? nxt.life : 3'd0;
				filled_total    <= (slot_ok || wr_en) ? nxt.filled : '0;
				error_code      <= (slot_ok || wr_en) ? nxt.error : 8'd0;
				fill_valid      <= fill;
				fill_instrument <= fill ? rd_rec.instrument : 16'd0;
				fill_venue      <= fill ? rd_rec.venue : 2'd0;
				fill_side       <= fill ? rd_rec.side : 1'b0;
				fill_price      <= fill ? cmd_q.price : '0;
				fill_quantity   <= fill ? cmd_q.quantity : '0;
				fill_time       <= fill ? cmd_q.time_ns : '0;
				fill_parent     <= fill ? rd_rec.parent : 32'd0;
			end
		end
	end

	// Command capture.
	always_ff @(posedge clk) begin
		if (cmd_take && cmd_valid) cmd_q <= cmd;
	end

endmodule

[design/order_lifecycle_table.sv]
// Order lifecycle table.
// Input channel (valid/stall): one word is a submit or an execution report for
// the order slot order_index. Output channel (out_valid/out_stall): exactly one
// result word per input word, in order, describing the slot after the update,
// plus a fill record when a fill report was applied.
// A two-entry queue decouples the input from the table sequencer, so input is
// taken while a result waits. The sequencer handles each word in order: take,
// memory read, then update and write back, an order RAM read-modify-write; it
// takes no new word until the result of the last one has been emitted.
// After reset a clearing pass over the ORDER_SLOTS slots (1024 by default) marks
// every slot empty; up to two words are queued meanwhile, then input stalls.
// While out_stall is high the result holds and the sequencer waits; the queue
// fills and then stall is raised on the input.
module order_lifecycle_table import olt_pkg::*; #(
	parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  logic               action,
	input  logic [IDX_W-1:0]   order_index,
	input  logic [2:0]         report_kind,
	input  logic [QTY_W-1:0]   quantity,
	input  logic [PRICE_W-1:0] price,
	input  logic [TIME_W-1:0]  time_ns,
	input  logic [15:0]        instrument,
	input  logic [1:0]         venue,
	input  logic               side,
	input  logic [31:0]        parent_id,
	input  logic [7:0]         reason_code,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               known,
	output logic [2:0]         order_status,
	output logic [QTY_W-1:0]   filled_total,
	output logic [7:0]         error_code,
	output logic               fill_valid,
	output logic [15:0]        fill_instrument,
	output logic [1:0]         fill_venue,
	output logic               fill_side,
	output logic [PRICE_W-1:0] fill_price,
	output logic [QTY_W-1:0]   fill_quantity,
	output logic [TIME_W-1:0]  fill_time,
	output logic [31:0]        fill_parent
);

	logic     cmd_valid, cmd_take;
	olt_cmd_t cmd;

	olt_front #(.ORDER_SLOTS(ORDER_SLOTS)) u_front (
		.clk, .arst_n, .valid, .stall, .action, .order_index, .report_kind,
		.quantity, .price, .time_ns, .instrument, .venue, .side, .parent_id,
		.reason_code, .cmd_valid, .cmd, .cmd_take
	);

	olt_back #(.ORDER_SLOTS(ORDER_SLOTS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take, .out_valid, .out_stall,
		.known, .order_status, .filled_total, .error_code, .fill_valid,
		.fill_instrument, .fill_venue, .fill_side, .fill_price, .fill_quantity,
		.fill_time, .fill_parent
	);

endmodule
